### rtl/bfts_pkg.sv
// shared types and constants for the brute force tour search block
package bfts_pkg;

   localparam int MAX_CITIES    = 6;
   localparam int MIN_CITIES    = 4;
   localparam int LENGTH_BITS   = 16;
   localparam int CITY_BITS     = 3;
   localparam int TOUR_LEN_BITS = 19;
   localparam int MEM_DEPTH     = MAX_CITIES * MAX_CITIES;
   localparam int ADDR_BITS     = $clog2(MEM_DEPTH);
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 3;

   localparam logic [TOUR_LEN_BITS-1:0] TOUR_BOUND = TOUR_LEN_BITS'(100000);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CITY_COUNT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_CITY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NO_TOUR   = 2'd1,
      STATUS_BAD_START = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]             from_city;
      logic [2:0]             to_city;
      logic [LENGTH_BITS-1:0] road_length;
      logic                   load_done;
   } req_type;

   typedef struct packed {
      logic [TOUR_LEN_BITS-1:0] tour_length;
      logic [2:0]               position;
      logic [2:0]               city;
      status_type               status;
      logic                     last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // matrix entry beat accepted
      logic init;       // clear search state
      logic cand_load;  // start summing the current candidate
      logic rd_issue;   // read one edge of the candidate
      logic compare;    // keep candidate if strictly shorter
      logic step;       // advance to next candidate
      logic emit;       // send one result beat
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_bad;
      logic cand_ok;
      logic edge_last;
      logic wrap;
      logic emit_last;
   } stat_type;

endpackage

### rtl/bfts_ctrl.sv
// sequencing state machine for the tour search
module bfts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               load_done,
   input  bfts_pkg::stat_type stat,
   output bfts_pkg::cmd_type  cmd,
   output logic               busy
);
   import bfts_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_INIT    = 7'b0000010,
      ST_CHECK   = 7'b0000100,
      ST_READ    = 7'b0001000,
      ST_DRAIN   = 7'b0010000,
      ST_COMPARE = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start && load_done) state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = stat.start_bad ? ST_EMIT : ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.cand_ok) begin
               cmd.cand_load = 1'b1;
               state_in      = ST_READ;
            end else begin
               // skip orderings that repeat a city
               cmd.step = 1'b1;
               state_in = stat.wrap ? ST_EMIT : ST_CHECK;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            if (stat.edge_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            cmd.step    = 1'b1;
            state_in    = stat.wrap ? ST_EMIT : ST_CHECK;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (stat.emit_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/bfts_datapath.sv
// matrix memory, candidate odometer, tour summing and result register
module bfts_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfts_pkg::cmd_type                    cmd,
   input  bfts_pkg::req_type                    req_data,
   input  logic                                 csr_we,
   input  logic [bfts_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bfts_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output bfts_pkg::stat_type                   stat,
   output logic                                 rsp_strobe,
   output bfts_pkg::rsp_type                    rsp_data
);
   import bfts_pkg::*;

   localparam logic [CITY_BITS-1:0] N_MAX = CITY_BITS'(MAX_CITIES);
   localparam logic [CITY_BITS-1:0] N_MIN = CITY_BITS'(MIN_CITIES);

   // config registers
   logic [CITY_BITS-1:0] city_count_ff, start_city_ff;
   logic [CITY_BITS-1:0] n_eff;

   // matrix store
   logic [LENGTH_BITS-1:0] dist_mem [MEM_DEPTH];
   logic [LENGTH_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
   logic                   wr_en;
   logic [CITY_BITS-1:0]   edge_a, edge_b;

   // candidate and search state
   logic [CITY_BITS-1:0]     digit_ff [1:MAX_CITIES-1];
   logic [CITY_BITS-1:0]     digit_in [1:MAX_CITIES-1];
   logic [CITY_BITS-1:0]     order [MAX_CITIES];
   logic [CITY_BITS-1:0]     rot_ff [MAX_CITIES];
   logic [CITY_BITS-1:0]     best_tour_ff [MAX_CITIES];
   logic [CITY_BITS-1:0]     edge_ff, emit_pos_ff;
   logic [TOUR_LEN_BITS-1:0] sum_ff, best_len_ff;
   logic                     found_ff;
   logic                     carry, cand_ok, improve;
   logic [CITY_BITS-1:0]     emit_city;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_strobe_ff;

   always_comb begin
      if (city_count_ff < N_MIN)      n_eff = N_MIN;
      else if (city_count_ff > N_MAX) n_eff = N_MAX;
      else                            n_eff = city_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= N_MIN;
         start_city_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CITY_COUNT: city_count_ff <= csr_wdata;
            CSR_START_CITY: start_city_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // matrix write on load beats, read one edge a cycle while summing
   assign wr_en   = cmd.load && (req_data.from_city < N_MAX) && (req_data.to_city < N_MAX);
   assign wr_addr = ADDR_BITS'(int'(req_data.from_city) * MAX_CITIES + int'(req_data.to_city));
   assign edge_a  = rot_ff[0];
   assign edge_b  = (edge_ff == n_eff - 1'b1) ? start_city_ff : rot_ff[1];
   assign rd_addr = ADDR_BITS'(int'(edge_a) * MAX_CITIES + int'(edge_b));

   always_ff @(posedge clock) begin
      if (wr_en) dist_mem[wr_addr] <= req_data.road_length;
      if (cmd.rd_issue) rd_data_ff <= dist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else       rd_valid_ff <= cmd.rd_issue;
   end

   // candidate ordering, start city first
   always_comb begin
      order[0] = start_city_ff;
      for (int i = 1; i < MAX_CITIES; i++) order[i] = digit_ff[i];
   end

   always_comb begin
      cand_ok = 1'b1;
      for (int i = 0; i < MAX_CITIES; i++)
         for (int j = i + 1; j < MAX_CITIES; j++)
            if ((CITY_BITS'(j) < n_eff) && (order[i] == order[j])) cand_ok = 1'b0;
   end

   // base-n odometer, last position changes fastest
   always_comb begin
      carry = 1'b1;
      for (int i = MAX_CITIES - 1; i >= 1; i--) begin
         digit_in[i] = digit_ff[i];
         if ((CITY_BITS'(i) < n_eff) && carry) begin
            if (digit_ff[i] == n_eff - 1'b1) begin
               digit_in[i] = '0;
            end else begin
               digit_in[i] = digit_ff[i] + 1'b1;
               carry       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         for (int i = 1; i < MAX_CITIES; i++) digit_ff[i] <= '0;
      end else if (cmd.step) begin
         for (int i = 1; i < MAX_CITIES; i++) digit_ff[i] <= digit_in[i];
      end
   end

   // rotating copy of the candidate feeds the edge reads
   always_ff @(posedge clock) begin
      if (cmd.cand_load) begin
         for (int i = 0; i < MAX_CITIES; i++) rot_ff[i] <= order[i];
      end else if (cmd.rd_issue) begin
         for (int i = 0; i < MAX_CITIES - 1; i++) rot_ff[i] <= rot_ff[i + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cand_load)     edge_ff <= '0;
      else if (cmd.rd_issue) edge_ff <= edge_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.cand_load)     sum_ff <= '0;
      else if (rd_valid_ff)  sum_ff <= sum_ff + TOUR_LEN_BITS'(rd_data_ff);
   end

   assign improve = cmd.compare && (sum_ff < best_len_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         best_len_ff <= TOUR_BOUND;
         found_ff    <= 1'b0;
      end else if (improve) begin
         best_len_ff <= sum_ff;
         found_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (improve) begin
         for (int i = 0; i < MAX_CITIES; i++) best_tour_ff[i] <= order[i];
      end
   end

   // result beats
   always_ff @(posedge clock) begin
      if (cmd.init)      emit_pos_ff <= '0;
      else if (cmd.emit) emit_pos_ff <= emit_pos_ff + 1'b1;
   end

   assign emit_city = (emit_pos_ff == n_eff) ? best_tour_ff[0] : best_tour_ff[emit_pos_ff];

   always_comb begin
      rsp_in = '0;
      if (stat.start_bad) begin
         rsp_in.status = STATUS_BAD_START;
         rsp_in.last   = 1'b1;
      end else if (!found_ff) begin
         rsp_in.status = STATUS_NO_TOUR;
         rsp_in.last   = 1'b1;
      end else begin
         rsp_in.tour_length = best_len_ff;
         rsp_in.position    = emit_pos_ff;
         rsp_in.city        = emit_city;
         rsp_in.status      = STATUS_FOUND;
         rsp_in.last        = (emit_pos_ff == n_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= cmd.emit;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign stat.start_bad = (start_city_ff >= n_eff);
   assign stat.cand_ok   = cand_ok;
   assign stat.edge_last = (edge_ff == n_eff - 1'b1);
   assign stat.wrap      = carry;
   assign stat.emit_last = rsp_in.last;

endmodule

### rtl/brute_force_tour_search.sv
// top level of the exhaustive shortest tour search
// matrix load beats are taken one per cycle while busy is low and give no result
// a beat with load_done starts the search: every odometer ordering is checked, and each
//   valid tour is summed from its edge reads through the single read port of the matrix
//   store, then drained and compared against the best tour so far
// result beats follow on consecutive cycles, n+1 of them or one on a status, strobed once each
// synchronous active high reset; matrix contents are not cleared and are undefined until loaded
module brute_force_tour_search (
   input  logic                                clock,
   input  logic                                reset,
   // load beats
   input  logic                                start,
   output logic                                busy,
   input  bfts_pkg::req_type                   req_data,
   // result beats, no back pressure
   output logic                                rsp_strobe,
   output bfts_pkg::rsp_type                   rsp_data,
   // register writes
   input  logic                                csr_we,
   input  logic [bfts_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bfts_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bfts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: walks init, candidate check, edge reads, drain, compare and emit
   bfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .load_done (req_data.load_done),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   // storage and arithmetic: matrix, odometer, running sum, best tour, result register
   bfts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
